/* rtl/i2da_pkg.sv */
// ----------------------------------------------------------------------------
// i2da_pkg
// shared types and constants of the 64-bit binary to decimal ascii converter
// ----------------------------------------------------------------------------
package i2da_pkg;

    localparam int DIGITS        = 20;
    localparam int BCD_W         = 4 * DIGITS;
    localparam int VALUE_W       = 64;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef struct packed {
        logic                 kind;
        logic [VALUE_W-1:0]   value;
        logic [7:0]           buffer_length;
    } t_in_word;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       fits;
        logic [4:0] string_length;
    } t_out_word;

    typedef struct packed {
        logic                 neg;
        logic [VALUE_W-1:0]   mag;
        logic [7:0]           cap;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_EMIT
    } t_back_state;

endpackage

/* rtl/i2da_stream_if.sv */
// ----------------------------------------------------------------------------
// i2da_stream_if
// valid/ready channel carrying one word per handshake
// ----------------------------------------------------------------------------
interface i2da_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/i2da_front.sv */
// ----------------------------------------------------------------------------
// i2da_front
// accepts input words, finds sign and magnitude, pushes jobs into the queue
// ----------------------------------------------------------------------------
module i2da_front
    import i2da_pkg::*;
(
    i2da_stream_if.sink i_in,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic w_neg;

    assign w_neg        = i_in.data.kind & i_in.data.value[VALUE_W-1];
    assign i_in.ready   = ~i_full;
    assign o_push       = i_in.valid & ~i_full;
    assign o_job.neg    = w_neg;
    assign o_job.mag    = w_neg ? (~i_in.data.value + VALUE_W'(1)) : i_in.data.value;
    assign o_job.cap    = i_in.data.buffer_length;

endmodule

/* rtl/i2da_fifo.sv */
// ----------------------------------------------------------------------------
// i2da_fifo
// short job queue between front and back
// ----------------------------------------------------------------------------
module i2da_fifo
    import i2da_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_pop_data,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_push, w_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign w_push     = i_push & ~o_full;
    assign w_pop      = i_pop & ~o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* rtl/i2da_back.sv */
// ----------------------------------------------------------------------------
// i2da_back
// bit-serial double dabble, leading zero trim and character output
// ----------------------------------------------------------------------------
module i2da_back
    import i2da_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  t_job            i_job,
    output logic            o_job_pop,
    i2da_stream_if.source   o_out
);

    t_back_state        r_state, n_state;
    logic [VALUE_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [5:0]         r_cnt, n_cnt;
    logic [4:0]         r_ndig, n_ndig;
    logic               r_neg, n_neg;
    logic [7:0]         r_cap, n_cap;
    logic [4:0]         r_len, n_len;
    logic               r_fit, n_fit;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    logic               w_out_free;
    logic [BCD_W-1:0]   w_adj;
    logic [3:0]         w_top;
    logic [5:0]         w_len;
    logic               w_trim;

    assign w_out_free  = ~r_out_valid | o_out.ready;
    assign w_top       = r_bcd[BCD_W-1 -: 4];
    assign w_len       = {1'b0, r_ndig} + {5'b0, r_neg};
    assign w_trim      = (w_top == 4'd0) && (r_ndig > 5'd1);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // add-3 correction on every digit
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            w_adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? r_bcd[d*4 +: 4] + 4'd3
                                                        : r_bcd[d*4 +: 4];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (r_cnt == 6'd0) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!w_trim) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free && (!r_fit || (!r_neg && r_ndig == 5'd0))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_ndig      = r_ndig;
        n_neg       = r_neg;
        n_cap       = r_cap;
        n_len       = r_len;
        n_fit       = r_fit;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~o_out.ready;
        o_job_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_bin     = i_job.mag;
                    n_bcd     = '0;
                    n_neg     = i_job.neg;
                    n_cap     = i_job.cap;
                    n_cnt     = 6'(VALUE_W - 1);
                    n_ndig    = 5'(DIGITS);
                end
            end
            S_CONV: begin
                n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt - 6'd1;
            end
            S_SCAN: begin
                if (w_trim) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig = r_ndig - 5'd1;
                end else begin
                    n_len = w_len[4:0];
                    n_fit = ({2'b00, w_len} < r_cap);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (!r_fit) begin
                        n_out = '{character: CHAR_NUL, last: 1'b1, fits: 1'b0,
                                  string_length: 5'd0};
                    end else if (r_neg) begin
                        n_out = '{character: CHAR_MINUS, last: 1'b0, fits: 1'b1,
                                  string_length: r_len};
                        n_neg = 1'b0;
                    end else if (r_ndig != 5'd0) begin
                        n_out = '{character: CHAR_ZERO + {4'd0, w_top}, last: 1'b0,
                                  fits: 1'b1, string_length: r_len};
                        n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                        n_ndig = r_ndig - 5'd1;
                    end else begin
                        n_out = '{character: CHAR_NUL, last: 1'b1, fits: 1'b1,
                                  string_length: r_len};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_ndig <= n_ndig;
        r_neg  <= n_neg;
        r_cap  <= n_cap;
        r_len  <= n_len;
        r_fit  <= n_fit;
        r_out  <= n_out;
    end

endmodule

/* rtl/int64_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii
// 64-bit binary to decimal ascii string converter
// ----------------------------------------------------------------------------
// Each input word holds a 64-bit value, a signed/unsigned kind flag and a
// buffer capacity. Input words are taken into a short job queue right away,
// so the source only waits when the queue is full. The converter works on one
// job at a time: it loads the job, runs bit-serial double dabble over all 64
// bits, trims leading zero digits one by one, sizes the string, then sends one
// output word per cycle while the sink is ready (digits, an optional leading
// minus sign and a final terminator, or a single rejection word).
module int64_to_decimal_ascii
    import i2da_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2da_stream_if.sink   i_in,
    i2da_stream_if.source o_out
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_push_job;
    t_job w_pop_job;

    i2da_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_job  (w_push_job)
    );

    i2da_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_job),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_job),
        .o_empty     (w_empty)
    );

    i2da_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (~w_empty),
        .i_job       (w_pop_job),
        .o_job_pop   (w_pop),
        .o_out       (o_out)
    );

endmodule

/* verif/int64_to_decimal_ascii_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii_tb
// self-checking testbench of the 64-bit binary to decimal ascii converter
// ----------------------------------------------------------------------------
// A queue of conversion requests is filled up front. It starts with directed
// corner values: zero, all ones, the most negative signed value, decade
// boundaries, and capacities at and around the string length. After those
// come random requests, most of them sized to fit. A clocked driver offers
// them on the input channel. Every accepted word is run through a local model
// that queues the expected characters. A clocked monitor compares each output
// word with the oldest expected one. Idling on both channels changes by
// phase. The run also has a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii_tb
    import i2da_pkg::*;
;

    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 148;
    localparam int DRAIN_AT     = 25;
    localparam int HOLD_AT      = 35;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 120;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_word  in_data    = '0;
    logic      out_ready  = 1'b0;
    logic      sink_hold  = 1'b0;
    int        gap_pct    = 0;
    int        stall_pct  = 0;

    t_in_word  pending_words[$];
    t_out_word expected_chars[$];

    int n_accepted = 0;
    int n_results  = 0;
    int n_rejected = 0;
    int n_errors   = 0;
    bit drain_wait = 1'b0;

    i2da_stream_if #(.T(t_in_word))  in_if ();
    i2da_stream_if #(.T(t_out_word)) out_if ();

    assign in_if.valid  = in_valid;
    assign in_if.data   = in_data;
    assign out_if.ready = out_ready;

    int64_to_decimal_ascii i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    function automatic int decimal_length(logic kind, logic [63:0] value);
        logic        neg;
        logic [63:0] mag;
        int          n;
        neg = kind & value[63];
        mag = neg ? (~value + 64'd1) : value;
        n   = 1;
        while (mag >= 64'd10) begin
            mag = mag / 64'd10;
            n++;
        end
        return n + int'(neg);
    endfunction

    function automatic void predict_string(t_in_word w);
        logic        neg;
        logic [63:0] mag;
        logic [7:0]  txt [DIGITS];
        int          len;
        int          pos;
        t_out_word   r;
        neg = w.kind & w.value[63];
        mag = neg ? (~w.value + 64'd1) : w.value;
        len = decimal_length(w.kind, w.value);
        if (len >= int'(w.buffer_length)) begin
            r = '{character: CHAR_NUL, last: 1'b1, fits: 1'b0, string_length: 5'd0};
            expected_chars.push_back(r);
            n_rejected++;
            return;
        end
        pos = len;
        do begin
            pos--;
            txt[pos] = CHAR_ZERO + 8'(mag % 64'd10);
            mag      = mag / 64'd10;
        end while (mag != 64'd0 && pos > 0);
        if (neg) begin
            txt[0] = CHAR_MINUS;
        end
        for (int k = 0; k < len; k++) begin
            r = '{character: txt[k], last: 1'b0, fits: 1'b1, string_length: 5'(len)};
            expected_chars.push_back(r);
        end
        r = '{character: CHAR_NUL, last: 1'b1, fits: 1'b1, string_length: 5'(len)};
        expected_chars.push_back(r);
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin : drive
        logic gap;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_if.ready) begin
                predict_string(in_data);
                n_accepted++;
                if (n_accepted == DRAIN_AT) begin
                    drain_wait = 1'b1;
                end
                if (n_accepted < 50) begin
                    gap_pct <= 0;  stall_pct <= 0;
                end else if (n_accepted < 90) begin
                    gap_pct <= 50; stall_pct <= 0;
                end else if (n_accepted < 130) begin
                    gap_pct <= 0;  stall_pct <= 50;
                end else if (n_accepted < 170) begin
                    gap_pct <= 27; stall_pct <= 27;
                end else begin
                    gap_pct <= 0;  stall_pct <= 0;
                end
            end
            if (drain_wait && expected_chars.size() == 0) begin
                drain_wait = 1'b0;
            end
            gap = (gap_pct != 0) && ($urandom_range(0, 99) < gap_pct);
            if (!in_valid || in_if.ready) begin
                if (pending_words.size() != 0 && !gap && !drain_wait) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_words.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch
        t_out_word exp_w;
        t_out_word got_w;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_if.valid && out_ready) begin
                got_w = out_if.data;
                n_results++;
                if (expected_chars.size() == 0) begin
                    $display("%0t unexpected word: got char %h last %b fits %b len %0d",
                             $time, got_w.character, got_w.last, got_w.fits,
                             got_w.string_length);
                    n_errors++;
                end else begin
                    exp_w = expected_chars.pop_front();
                    if (got_w.character !== exp_w.character || got_w.last !== exp_w.last ||
                        got_w.fits !== exp_w.fits ||
                        got_w.string_length !== exp_w.string_length) begin
                        $display("%0t mismatch: expected char %h last %b fits %b len %0d, got char %h last %b fits %b len %0d",
                                 $time, exp_w.character, exp_w.last, exp_w.fits,
                                 exp_w.string_length, got_w.character, got_w.last,
                                 got_w.fits, got_w.string_length);
                        n_errors++;
                    end
                end
            end
            out_ready <= !sink_hold &&
                         (stall_pct == 0 || $urandom_range(0, 99) >= stall_pct);
        end
    end

    // long output hold-off while the sender keeps offering
    initial begin
        wait (n_accepted >= HOLD_AT);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : main
        t_in_word w;
        int       len;
        w = '0;
        w = '{kind: 1'b0, value: 64'd0, buffer_length: 8'd2};   pending_words.push_back(w);
        w = '{kind: 1'b0, value: 64'd0, buffer_length: 8'd1};   pending_words.push_back(w);
        w = '{kind: 1'b0, value: 64'd0, buffer_length: 8'd0};   pending_words.push_back(w);
        w = '{kind: 1'b1, value: 64'd0, buffer_length: 8'd255}; pending_words.push_back(w);
        w = '{kind: 1'b0, value: '1, buffer_length: 8'd255};    pending_words.push_back(w);
        w = '{kind: 1'b0, value: '1, buffer_length: 8'd21};     pending_words.push_back(w);
        w = '{kind: 1'b0, value: '1, buffer_length: 8'd20};     pending_words.push_back(w);
        w = '{kind: 1'b1, value: '1, buffer_length: 8'd3};      pending_words.push_back(w);
        w = '{kind: 1'b1, value: '1, buffer_length: 8'd2};      pending_words.push_back(w);
        w = '{kind: 1'b1, value: 64'h8000_0000_0000_0000, buffer_length: 8'd21};
        pending_words.push_back(w);
        w = '{kind: 1'b1, value: 64'h8000_0000_0000_0000, buffer_length: 8'd20};
        pending_words.push_back(w);
        w = '{kind: 1'b0, value: 64'h8000_0000_0000_0000, buffer_length: 8'd255};
        pending_words.push_back(w);
        w = '{kind: 1'b1, value: 64'h7FFF_FFFF_FFFF_FFFF, buffer_length: 8'd255};
        pending_words.push_back(w);
        w = '{kind: 1'b0, value: 64'd9, buffer_length: 8'd2};   pending_words.push_back(w);
        w = '{kind: 1'b0, value: 64'd10, buffer_length: 8'd3};  pending_words.push_back(w);
        w = '{kind: 1'b0, value: 64'd10, buffer_length: 8'd2};  pending_words.push_back(w);
        w = '{kind: 1'b1, value: -64'd10, buffer_length: 8'd4}; pending_words.push_back(w);
        w = '{kind: 1'b1, value: 64'd123, buffer_length: 8'd255};
        pending_words.push_back(w);
        w = '{kind: 1'b0, value: 64'd10000000000000000000, buffer_length: 8'd255};
        pending_words.push_back(w);
        w = '{kind: 1'b0, value: 64'd9999999999999999999, buffer_length: 8'd255};
        pending_words.push_back(w);
        w = '{kind: 1'b0, value: 64'h5555_5555_5555_5555, buffer_length: 8'd255};
        pending_words.push_back(w);
        w = '{kind: 1'b1, value: 64'hAAAA_AAAA_AAAA_AAAA, buffer_length: 8'd255};
        pending_words.push_back(w);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            w.kind = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
                0: w.value = {$urandom, $urandom};
                1: w.value = {$urandom, $urandom} >> $urandom_range(0, 63);
                2: w.value = 64'($urandom_range(0, 999));
                3: w.value = -64'($urandom_range(1, 100000));
                default: w.value = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
            endcase
            len = decimal_length(w.kind, w.value);
            case ($urandom_range(0, 19))
                0, 1, 2:    w.buffer_length = 8'(len + $urandom_range(0, 1));
                3, 4, 5:    w.buffer_length = 8'($urandom_range(0, 255));
                default:    w.buffer_length = 8'($urandom_range(len + 1, 255));
            endcase
            pending_words.push_back(w);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_chars.size() != 0) begin
            $display("%0t %0d expected words never arrived", $time, expected_chars.size());
            n_errors++;
        end
        $display("converted %0d values (%0d rejected), checked %0d output words",
                 n_accepted, n_rejected, n_results);
        $display("phases: free running, input gaps, output stalls, both, long hold-off");
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
